// ===== src/bed_pkg.sv =====
// Shared types and constants of the backslash escape decoder.
package bed_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic [1:0] error_code;
        logic       run_last;
        logic       stream_end;
    } out_t;

    // Up to two results produced by one decoded byte
    typedef struct packed {
        logic [1:0] cnt;
        out_t       r0;
        out_t       r1;
    } res_pair_t;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TRAILING = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX  = 2'd2;

    // Invalid hex escape handling modes
    localparam logic [1:0] MODE_STRICT  = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_IGNORE  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_B  = 8'h62;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LOWER_V  = 8'h76;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_SEVEN    = 8'h37;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;

    // Control bytes produced by the simple escapes
    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;

    // Result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ===== src/bed_decode.sv =====
// Escape parser: phase state and the single-pass decode of one byte into results.
module bed_decode
    import bed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  in_t        item,
    input  logic [1:0] error_mode,
    output res_pair_t  res
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_OCT1  = 3'd2,
        PH_OCT2  = 3'd3,
        PH_X0    = 3'd4,
        PH_X1    = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] acc_reg, acc_next;
    logic [3:0] nib_reg, nib_next;
    logic       failed_reg, failed_next;

    logic [7:0] b;
    logic       last;
    logic       hex_ok;
    logic [3:0] hex_nib;
    logic       oct_ok;
    logic [2:0] oct_dig;
    logic       strict;
    logic       bad_hex;
    logic       do_plain;
    logic       lead_v;
    out_t       lead;
    logic       plain_v;
    out_t       plain;
    logic [8:0] acc_shift;

    assign b       = item.in_byte;
    assign last    = item.is_last;
    assign oct_ok  = (b >= CH_ZERO) && (b <= CH_SEVEN);
    assign oct_dig = b[2:0];
    assign strict  = (error_mode != MODE_REPLACE) && (error_mode != MODE_IGNORE);
    assign acc_shift = {acc_reg[5:0], 3'b000} + {6'd0, oct_dig};

    // Hex digit recognition, either case
    always_comb begin
        hex_ok  = 1'b0;
        hex_nib = 4'd0;
        if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            hex_ok  = 1'b1;
            hex_nib = b[3:0];
        end else if ((b >= CH_LOWER_A) && (b <= CH_LOWER_F)) begin
            hex_ok  = 1'b1;
            hex_nib = b[3:0] + 4'd9;
        end else if ((b >= CH_UPPER_A) && (b <= CH_UPPER_F)) begin
            hex_ok  = 1'b1;
            hex_nib = b[3:0] + 4'd9;
        end
    end

    // Phase decode: an optional leading result, then optionally the byte taken as plain text
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        nib_next    = nib_reg;
        failed_next = failed_reg;
        bad_hex     = 1'b0;
        do_plain    = 1'b0;
        lead_v      = 1'b0;
        lead        = '0;
        lead.has_data = 1'b1;
        plain_v     = 1'b0;
        plain       = '0;
        res         = '0;

        if (!failed_reg) begin
            case (phase_reg)
                PH_ESC: begin
                    phase_next = PH_PLAIN;
                    case (b)
                        CH_NEWLINE: begin
                        end
                        CH_BSLASH: begin
                            lead_v = 1'b1;
                            lead.out_byte = CH_BSLASH;
                        end
                        CH_SQUOTE: begin
                            lead_v = 1'b1;
                            lead.out_byte = CH_SQUOTE;
                        end
                        CH_DQUOTE: begin
                            lead_v = 1'b1;
                            lead.out_byte = CH_DQUOTE;
                        end
                        CH_LOWER_B: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_BS;
                        end
                        CH_LOWER_F: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_FF;
                        end
                        CH_LOWER_T: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_HT;
                        end
                        CH_LOWER_N: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_LF;
                        end
                        CH_LOWER_R: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_CR;
                        end
                        CH_LOWER_V: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_VT;
                        end
                        CH_LOWER_A: begin
                            lead_v = 1'b1;
                            lead.out_byte = CTL_BEL;
                        end
                        CH_LOWER_X: begin
                            if (last) begin
                                bad_hex = 1'b1;
                            end else begin
                                phase_next = PH_X0;
                            end
                        end
                        default: begin
                            if (oct_ok) begin
                                acc_next = {6'd0, oct_dig};
                                if (last) begin
                                    lead_v = 1'b1;
                                    lead.out_byte = {5'd0, oct_dig};
                                end else begin
                                    phase_next = PH_OCT1;
                                end
                            end else begin
                                // Unknown escape: the backslash survives
                                lead_v = 1'b1;
                                lead.out_byte = CH_BSLASH;
                                do_plain = 1'b1;
                            end
                        end
                    endcase
                end
                PH_OCT1: begin
                    if (oct_ok) begin
                        acc_next = acc_shift;
                        if (last) begin
                            lead_v = 1'b1;
                            lead.out_byte = acc_shift[7:0];
                            phase_next = PH_PLAIN;
                        end else begin
                            phase_next = PH_OCT2;
                        end
                    end else begin
                        lead_v = 1'b1;
                        lead.out_byte = acc_reg[7:0];
                        do_plain = 1'b1;
                    end
                end
                PH_OCT2: begin
                    if (oct_ok) begin
                        lead_v = 1'b1;
                        lead.out_byte = acc_shift[7:0];
                        phase_next = PH_PLAIN;
                    end else begin
                        lead_v = 1'b1;
                        lead.out_byte = acc_reg[7:0];
                        do_plain = 1'b1;
                    end
                end
                PH_X0: begin
                    if (hex_ok && !last) begin
                        nib_next   = hex_nib;
                        phase_next = PH_X1;
                    end else begin
                        // A hex digit here is swallowed by the bad escape
                        bad_hex  = 1'b1;
                        do_plain = !strict && !hex_ok;
                    end
                end
                PH_X1: begin
                    phase_next = PH_PLAIN;
                    if (hex_ok) begin
                        lead_v = 1'b1;
                        lead.out_byte = {nib_reg, hex_nib};
                    end else begin
                        bad_hex  = 1'b1;
                        do_plain = !strict;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase

            // Invalid hex escape handling
            if (bad_hex) begin
                phase_next = PH_PLAIN;
                if (error_mode == MODE_REPLACE) begin
                    lead_v = 1'b1;
                    lead.out_byte = CH_QUESTION;
                end else if (error_mode != MODE_IGNORE) begin
                    lead_v = 1'b1;
                    lead.has_data = 1'b0;
                    lead.error_code = ERR_BAD_HEX;
                    failed_next = 1'b1;
                end
            end

            // The byte as plain text
            if (do_plain) begin
                if (b == CH_BSLASH) begin
                    if (last) begin
                        plain_v = 1'b1;
                        plain.error_code = ERR_TRAILING;
                    end else begin
                        phase_next = PH_ESC;
                    end
                end else begin
                    plain_v = 1'b1;
                    plain.out_byte = b;
                    plain.has_data = 1'b1;
                    phase_next = PH_PLAIN;
                end
            end
        end

        // The end of a stream returns the parser to its reset state
        if (last) begin
            phase_next  = PH_PLAIN;
            acc_next    = '0;
            nib_next    = '0;
            failed_next = 1'b0;
        end

        // Pack the results in order and mark the final one
        if (lead_v) begin
            res.r0 = lead;
            if (plain_v) begin
                res.r1 = plain;
            end
        end else if (plain_v) begin
            res.r0 = plain;
        end
        res.cnt = {1'b0, lead_v} + {1'b0, plain_v};
        if (last && (res.cnt == 2'd0)) begin
            res.cnt = 2'd1;
        end
        if (res.cnt == 2'd2) begin
            res.r1.run_last   = 1'b1;
            res.r1.stream_end = last;
        end else begin
            res.r0.run_last   = 1'b1;
            res.r0.stream_end = last;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PLAIN;
            acc_reg    <= '0;
            nib_reg    <= '0;
            failed_reg <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            nib_reg    <= nib_next;
            failed_reg <= failed_next;
        end
    end

`ifndef SYNTH
    // A stream end always leaves the parser clean.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.is_last |=> (phase_reg == PH_PLAIN) && !failed_reg && (acc_reg == 9'd0))
        else $error("parser state not cleared at stream end");

    // The final byte of a stream always produces at least one result.
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.is_last |-> (res.cnt != 2'd0))
        else $error("stream end produced no result");

    // After a strict error, bytes before the stream end yield nothing.
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && failed_reg && !item.is_last |-> (res.cnt == 2'd0))
        else $error("result produced while dropping input");
`endif

endmodule

// ===== src/bed_result_queue.sv =====
// Four-entry result queue taking up to two results per cycle and giving one.
module bed_result_queue
    import bed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] wr_cnt,
    input  out_t       wr_data0,
    input  out_t       wr_data1,
    input  logic       rd_en,
    output out_t       rd_data,
    output logic       not_empty,
    output logic [2:0] count
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    out_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign rd_data      = entry_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != 3'd0);
    assign count        = count_reg;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + wr_cnt[PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + {{(PTR_W-1){1'b0}}, rd_en};
        count_next  = count_reg + {1'b0, wr_cnt} - {2'b00, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_cnt == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

`ifndef SYNTH
    // Occupancy never exceeds the depth.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A write only arrives when it fits.
    a_write_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_cnt != 2'd0) |-> ({1'b0, count_reg} + {2'b00, wr_cnt} <= 4'(QUEUE_DEPTH)))
        else $error("write into a full result queue");

    // Reads only from a non-empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (count_reg != 3'd0))
        else $error("read from an empty result queue");
`endif

endmodule

// ===== src/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder: input register, parser and result queue.
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+----------------------------------
//  input   | s_valid, s_ready, s_data       | in_t: in_byte, is_last
//  result  | m_valid, m_ready, m_data       | out_t: out_byte, has_data,
//          |                                |   error_code, run_last, stream_end
//  config  | cfg_valid, cfg_ready, cfg_data | error_mode (2 bits)
//
// One byte is accepted per cycle while s_ready is high; its first result is offered once the byte has
// passed the input register and been written into the result queue. The result port delivers one result
// per cycle while m_ready is high, so bytes that give two results drain more slowly than they arrive;
// a four-entry queue absorbs the difference. Reset (aresetn low, synchronous) clears the parser, the
// queue and error_mode. A stalled result port backs up into the input register and then drops s_ready.
module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    in_t        in_reg;
    logic       in_valid_reg, in_valid_next;
    logic [1:0] mode_reg;
    logic       fire;
    logic       s_take;
    logic [2:0] q_count;
    logic [1:0] wr_cnt;
    res_pair_t  res;

    // The parser advances when a byte is held and the queue has room for two results
    assign fire    = in_valid_reg && (q_count <= 3'(QUEUE_DEPTH - 2));
    assign s_ready = !in_valid_reg || fire;
    assign s_take  = s_valid && s_ready;
    assign wr_cnt  = fire ? res.cnt : 2'd0;
    assign cfg_ready = 1'b1;

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_STRICT;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    bed_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (in_reg),
        .error_mode (mode_reg),
        .res        (res)
    );

    bed_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_cnt    (wr_cnt),
        .wr_data0  (res.r0),
        .wr_data1  (res.r1),
        .rd_en     (m_valid && m_ready),
        .rd_data   (m_data),
        .not_empty (m_valid),
        .count     (q_count)
    );

endmodule
